[hdl/apt_pkg.sv]
// Shared types, constants and helpers for the aging peer table.
`timescale 1ns / 1ps
`default_nettype none

package apt_pkg;

   localparam int unsigned DEFAULT_TABLE_ENTRIES = 10;
   localparam int unsigned ADDR_W = 48;
   localparam int unsigned AGE_W = 8;
   localparam int unsigned OUT_W = 4;

   localparam logic [AGE_W-1:0] MAX_AGE_RESET = 8'd12;
   localparam logic [AGE_W-1:0] AGE_SATURATED = 8'hFF;

   // Appearance classes as carried on the request.
   localparam logic [1:0] CLASS_BADGE = 2'd1;
   localparam logic [1:0] CLASS_MAKER = 2'd2;

   typedef enum logic [2:0] {
      ACT_IGNORED   = 3'd0,
      ACT_REFRESHED = 3'd1,
      ACT_ADDED     = 3'd2,
      ACT_REPLACED  = 3'd3,
      ACT_TICK_DONE = 3'd4
   } action_type;

   typedef struct packed {
      logic              req_type;
      logic [ADDR_W-1:0] peer_address;
      logic [1:0]        address_kind;
      logic [1:0]        appearance_class;
      logic              marker_valid;
   } peer_req_type;

   typedef struct packed {
      action_type       action;
      logic [OUT_W-1:0] slot;
      logic [OUT_W-1:0] aged_out;
      logic [OUT_W-1:0] peer_total;
      logic [OUT_W-1:0] imposter_total;
      logic [OUT_W-1:0] maker_total;
   } peer_rsp_type;

   typedef struct packed {
      logic load;
      logic scan;
      logic commit;
      logic respond;
   } ctrl_cmd_type;

   typedef struct packed {
      logic needs_scan;
      logic is_tick;
      logic scan_done;
   } dp_status_type;

   function automatic logic is_maker(input logic [1:0] cls);
      return cls == CLASS_MAKER;
   endfunction

   function automatic logic is_imposter(input logic [1:0] cls);
      return (cls != CLASS_BADGE) && (cls != CLASS_MAKER);
   endfunction

endpackage

`default_nettype wire

[hdl/aging_peer_table.sv]
// Top level of the aging peer table: controller plus datapath.
// A sighting with the marker passes scan, commit and reply, a tick scan and reply,
// and a sighting without the marker goes straight to reply.
// One request at a time; the next can be accepted in the cycle the result shows.
// The scan walks one entry per cycle over the entry memory's single read port.
// Synchronous reset empties the table, clears the counts and sets max_age to 12.
`timescale 1ns / 1ps
`default_nettype none

module aging_peer_table #(
   parameter int unsigned TABLE_ENTRIES = apt_pkg::DEFAULT_TABLE_ENTRIES
) (
   input  wire                   clock,
   input  wire                   reset,
   input  wire                   start,
   output logic                  busy,
   input  wire apt_pkg::peer_req_type req_data,
   output logic                  rsp_valid,
   output apt_pkg::peer_rsp_type rsp_data,
   input  wire                   csr_wr_en,
   input  wire [7:0]             csr_wr_data
);
   import apt_pkg::*;

   ctrl_cmd_type  cmd;
   dp_status_type status;
   logic          ctrl_busy;

   apt_ctrl u_ctrl (
      .clock  (clock),
      .reset  (reset),
      .start  (start),
      .busy   (ctrl_busy),
      .status (status),
      .cmd    (cmd)
   );

   apt_datapath #(
      .TABLE_ENTRIES (TABLE_ENTRIES)
   ) u_datapath (
      .clock       (clock),
      .reset       (reset),
      .req_data    (req_data),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .cmd         (cmd),
      .status      (status),
      .rsp_valid   (rsp_valid),
      .rsp_data    (rsp_data)
   );

   assign busy = ctrl_busy;

endmodule

`default_nettype wire

[hdl/apt_ctrl.sv]
// Sequencing state machine for the aging peer table.
`timescale 1ns / 1ps
`default_nettype none

module apt_ctrl (
   input  wire                   clock,
   input  wire                   reset,
   input  wire                   start,
   output logic                  busy,
   input  wire apt_pkg::dp_status_type status,
   output apt_pkg::ctrl_cmd_type  cmd
);
   import apt_pkg::*;

   typedef enum logic [3:0] {
      ST_IDLE   = 4'b0001,
      ST_SCAN   = 4'b0010,
      ST_COMMIT = 4'b0100,
      ST_REPLY  = 4'b1000
   } state_type;

   state_type state_ff;
   state_type state_in;

   always_comb begin
      state_in = state_ff;
      cmd = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               cmd.load = 1'b1;
               state_in = status.needs_scan ? ST_SCAN : ST_REPLY;
            end
         end
         ST_SCAN: begin
            cmd.scan = 1'b1;
            if (status.scan_done) begin
               state_in = status.is_tick ? ST_REPLY : ST_COMMIT;
            end
         end
         ST_COMMIT: begin
            cmd.commit = 1'b1;
            state_in = ST_REPLY;
         end
         ST_REPLY: begin
            cmd.respond = 1'b1;
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign busy = (state_ff != ST_IDLE);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   a_accept_goes_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("controller did not go busy after accepting a request");

   a_commit_then_reply: assert property (@(posedge clock) disable iff (reset)
      cmd.commit |=> cmd.respond)
      else $error("table update was not followed by a reply");

   a_scan_ends: assert property (@(posedge clock) disable iff (reset)
      (cmd.scan && status.scan_done) |=> !cmd.scan)
      else $error("scan continued past the last entry");

endmodule

`default_nettype wire

[hdl/apt_datapath.sv]
// Entry storage, scan logic, counters and reply register for the peer table.
`timescale 1ns / 1ps
`default_nettype none

module apt_datapath #(
   parameter int unsigned TABLE_ENTRIES = apt_pkg::DEFAULT_TABLE_ENTRIES
) (
   input  wire                   clock,
   input  wire                   reset,
   input  wire apt_pkg::peer_req_type req_data,
   input  wire                   csr_wr_en,
   input  wire [7:0]             csr_wr_data,
   input  wire apt_pkg::ctrl_cmd_type cmd,
   output apt_pkg::dp_status_type status,
   output logic                  rsp_valid,
   output apt_pkg::peer_rsp_type rsp_data
);
   import apt_pkg::*;

   localparam int unsigned IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
   localparam int unsigned CNT_W = $clog2(TABLE_ENTRIES + 1);
   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_ENTRIES - 1);

   typedef struct packed {
      logic [ADDR_W-1:0] address;
      logic [1:0]        address_kind;
      logic [1:0]        appearance;
      logic [AGE_W-1:0]  age;
   } entry_type;

   // Peer data lives in a single-port-read memory; only the occupied bits reset.
   entry_type entry_mem [TABLE_ENTRIES];
   entry_type rd_ff;
   logic      rd_en;
   logic      wr_en;
   logic [IDX_W-1:0] wr_idx;
   entry_type wr_data;

   logic [AGE_W-1:0]         max_age_ff, max_age_in;
   peer_req_type             req_ff, req_in;
   logic [TABLE_ENTRIES-1:0] occ_ff, occ_in;
   logic [CNT_W-1:0]         occ_cnt_ff, occ_cnt_in;
   logic [CNT_W-1:0]         imp_cnt_ff, imp_cnt_in;
   logic [CNT_W-1:0]         mak_cnt_ff, mak_cnt_in;
   logic [CNT_W-1:0]         aged_ff, aged_in;
   logic [IDX_W-1:0]         rd_idx_ff, rd_idx_in;
   logic                     issue_done_ff, issue_done_in;
   logic                     pr_valid_ff, pr_valid_in;
   logic [IDX_W-1:0]         pr_idx_ff, pr_idx_in;
   logic                     found_ff, found_in;
   logic [IDX_W-1:0]         match_idx_ff, match_idx_in;
   logic [1:0]               match_cls_ff, match_cls_in;
   logic                     have_empty_ff, have_empty_in;
   logic [IDX_W-1:0]         empty_idx_ff, empty_idx_in;
   logic                     have_old_ff, have_old_in;
   logic [AGE_W-1:0]         old_age_ff, old_age_in;
   logic [IDX_W-1:0]         old_idx_ff, old_idx_in;
   logic [1:0]               old_cls_ff, old_cls_in;
   action_type               action_ff, action_in;
   logic [IDX_W-1:0]         slot_ff, slot_in;
   logic                     rsp_valid_ff, rsp_valid_in;
   peer_rsp_type             rsp_ff, rsp_in;

   logic [AGE_W-1:0]   age_inc;
   logic               hit;
   logic [IDX_W-1:0]   target;
   logic               add_imp, add_mak, rem_imp, rem_mak;
   logic [CNT_W+3:0]   occ_wide, imp_wide, mak_wide, aged_wide;
   logic [IDX_W+3:0]   slot_wide;

   assign status.needs_scan = req_data.req_type | req_data.marker_valid;
   assign status.is_tick    = req_ff.req_type;
   assign status.scan_done  = pr_valid_ff && (pr_idx_ff == LAST_IDX);

   assign rd_en = cmd.scan && !issue_done_ff;

   assign age_inc = (rd_ff.age == AGE_SATURATED) ? AGE_SATURATED : rd_ff.age + 8'd1;
   assign hit = (rd_ff.address == req_ff.peer_address) &&
                (rd_ff.address_kind == req_ff.address_kind);
   assign target = have_empty_ff ? empty_idx_ff : old_idx_ff;

   assign occ_wide  = {4'b0, occ_cnt_ff};
   assign imp_wide  = {4'b0, imp_cnt_ff};
   assign mak_wide  = {4'b0, mak_cnt_ff};
   assign aged_wide = {4'b0, aged_ff};
   assign slot_wide = {4'b0, slot_ff};

   always_comb begin
      max_age_in    = max_age_ff;
      req_in        = req_ff;
      occ_in        = occ_ff;
      occ_cnt_in    = occ_cnt_ff;
      imp_cnt_in    = imp_cnt_ff;
      mak_cnt_in    = mak_cnt_ff;
      aged_in       = aged_ff;
      rd_idx_in     = rd_idx_ff;
      issue_done_in = issue_done_ff;
      pr_valid_in   = 1'b0;
      pr_idx_in     = pr_idx_ff;
      found_in      = found_ff;
      match_idx_in  = match_idx_ff;
      match_cls_in  = match_cls_ff;
      have_empty_in = have_empty_ff;
      empty_idx_in  = empty_idx_ff;
      have_old_in   = have_old_ff;
      old_age_in    = old_age_ff;
      old_idx_in    = old_idx_ff;
      old_cls_in    = old_cls_ff;
      action_in     = action_ff;
      slot_in       = slot_ff;
      rsp_valid_in  = cmd.respond;
      rsp_in        = rsp_ff;
      wr_en         = 1'b0;
      wr_idx        = pr_idx_ff;
      wr_data       = rd_ff;
      add_imp       = 1'b0;
      add_mak       = 1'b0;
      rem_imp       = 1'b0;
      rem_mak       = 1'b0;

      if (csr_wr_en) begin
         max_age_in = csr_wr_data;
      end

      if (cmd.load) begin
         req_in        = req_data;
         rd_idx_in     = '0;
         issue_done_in = 1'b0;
         found_in      = 1'b0;
         have_empty_in = 1'b0;
         have_old_in   = 1'b0;
         aged_in       = '0;
         slot_in       = '0;
         action_in     = req_data.req_type ? ACT_TICK_DONE : ACT_IGNORED;
      end

      // Read issue: one entry per cycle, the data comes back in the next cycle.
      if (rd_en) begin
         pr_valid_in = 1'b1;
         pr_idx_in   = rd_idx_ff;
         if (rd_idx_ff == LAST_IDX) begin
            issue_done_in = 1'b1;
         end else begin
            rd_idx_in = rd_idx_ff + 1'b1;
         end
      end

      if (pr_valid_ff) begin
         if (occ_ff[pr_idx_ff]) begin
            if (req_ff.req_type) begin
               wr_en       = 1'b1;
               wr_data.age = age_inc;
               if (age_inc >= max_age_ff) begin
                  occ_in[pr_idx_ff] = 1'b0;
                  occ_cnt_in = occ_cnt_ff - 1'b1;
                  aged_in    = aged_ff + 1'b1;
                  rem_mak    = is_maker(rd_ff.appearance);
                  rem_imp    = is_imposter(rd_ff.appearance);
               end
            end else if (!found_ff) begin
               if (hit) begin
                  found_in     = 1'b1;
                  match_idx_in = pr_idx_ff;
                  match_cls_in = rd_ff.appearance;
               end else if (!have_old_ff || (rd_ff.age > old_age_ff)) begin
                  have_old_in = 1'b1;
                  old_age_in  = rd_ff.age;
                  old_idx_in  = pr_idx_ff;
                  old_cls_in  = rd_ff.appearance;
               end
            end
         end else if (!req_ff.req_type && !have_empty_ff) begin
            have_empty_in = 1'b1;
            empty_idx_in  = pr_idx_ff;
         end
      end

      if (cmd.commit) begin
         wr_en                = 1'b1;
         wr_data.address      = req_ff.peer_address;
         wr_data.address_kind = req_ff.address_kind;
         wr_data.appearance   = req_ff.appearance_class;
         wr_data.age          = '0;
         if (found_ff) begin
            wr_idx             = match_idx_ff;
            wr_data.appearance = match_cls_ff;
            action_in          = ACT_REFRESHED;
            slot_in            = match_idx_ff;
         end else begin
            wr_idx         = target;
            occ_in[target] = 1'b1;
            slot_in        = target;
            add_mak        = is_maker(req_ff.appearance_class);
            add_imp        = is_imposter(req_ff.appearance_class);
            if (have_empty_ff) begin
               occ_cnt_in = occ_cnt_ff + 1'b1;
               action_in  = ACT_ADDED;
            end else begin
               rem_mak   = is_maker(old_cls_ff);
               rem_imp   = is_imposter(old_cls_ff);
               action_in = ACT_REPLACED;
            end
         end
      end

      imp_cnt_in = imp_cnt_ff + CNT_W'(add_imp) - CNT_W'(rem_imp);
      mak_cnt_in = mak_cnt_ff + CNT_W'(add_mak) - CNT_W'(rem_mak);

      if (cmd.respond) begin
         rsp_in.action         = action_ff;
         rsp_in.slot           = slot_wide[3:0];
         rsp_in.aged_out       = aged_wide[3:0];
         rsp_in.peer_total     = occ_wide[3:0];
         rsp_in.imposter_total = imp_wide[3:0];
         rsp_in.maker_total    = mak_wide[3:0];
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         entry_mem[wr_idx] <= wr_data;
      end
      if (rd_en) begin
         rd_ff <= entry_mem[rd_idx_ff];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         max_age_ff    <= MAX_AGE_RESET;
         occ_ff        <= '0;
         occ_cnt_ff    <= '0;
         imp_cnt_ff    <= '0;
         mak_cnt_ff    <= '0;
         issue_done_ff <= 1'b1;
         pr_valid_ff   <= 1'b0;
         found_ff      <= 1'b0;
         have_empty_ff <= 1'b0;
         have_old_ff   <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         max_age_ff    <= max_age_in;
         occ_ff        <= occ_in;
         occ_cnt_ff    <= occ_cnt_in;
         imp_cnt_ff    <= imp_cnt_in;
         mak_cnt_ff    <= mak_cnt_in;
         issue_done_ff <= issue_done_in;
         pr_valid_ff   <= pr_valid_in;
         found_ff      <= found_in;
         have_empty_ff <= have_empty_in;
         have_old_ff   <= have_old_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      req_ff       <= req_in;
      aged_ff      <= aged_in;
      rd_idx_ff    <= rd_idx_in;
      pr_idx_ff    <= pr_idx_in;
      match_idx_ff <= match_idx_in;
      match_cls_ff <= match_cls_in;
      empty_idx_ff <= empty_idx_in;
      old_age_ff   <= old_age_in;
      old_idx_ff   <= old_idx_in;
      old_cls_ff   <= old_cls_in;
      action_ff    <= action_in;
      slot_ff      <= slot_in;
      rsp_ff       <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   a_single_reply: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |=> !rsp_valid_ff)
      else $error("two replies in consecutive cycles");

   a_count_matches_occupancy: assert property (@(posedge clock) disable iff (reset)
      occ_cnt_ff == CNT_W'($countones(occ_ff)))
      else $error("peer count disagrees with occupied entries");

   a_class_counts_bounded: assert property (@(posedge clock) disable iff (reset)
      ({1'b0, imp_cnt_ff} + {1'b0, mak_cnt_ff}) <= {1'b0, occ_cnt_ff})
      else $error("class counts exceed the peer count");

endmodule

`default_nettype wire
